// File: src/aces_tonemap_pixel_quantizer_defines.svh
// ----------------------------------------------------------------------------
// aces tonemap pixel quantizer assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef ACES_TONEMAP_PIXEL_QUANTIZER_DEFINES_SVH
`define ACES_TONEMAP_PIXEL_QUANTIZER_DEFINES_SVH

// same-cycle implication, masked while in reset
`define ACEQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aceq same-cycle check failed");

// next-cycle implication, masked while in reset
`define ACEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aceq next-cycle check failed");

// state right after a reset cycle
`define ACEQ_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("aceq reset check failed");

`endif

// File: src/aceq_pkg.sv
// ----------------------------------------------------------------------------
// aceq_pkg
// shared constants and types of the aces tonemap pixel quantizer
// ----------------------------------------------------------------------------
package aceq_pkg;

  localparam int InputWidthDef = 24;
  localparam int FracBits      = 16;
  localparam int XW            = 19;   // curve inputs below 8.0
  localparam int AW            = 27;   // 251*x + 3*one, 243*x + 59*one
  localparam int PW            = 47;   // num, den
  localparam int NW            = 56;   // 510*num + den
  localparam int DW            = 48;   // 2*den
  localparam int QBits         = 8;
  localparam int PolyLat       = 3;
  localparam int Lat           = PolyLat + QBits;

  localparam logic [7:0] ByteMax = 8'hFF;

  typedef struct packed {
    logic          byp;
    logic [7:0]    bval;
    logic [NW-1:0] n;
    logic [DW-1:0] d;
  } aceq_div_t;

endpackage

// File: src/aceq_poly.sv
// ----------------------------------------------------------------------------
// aceq_poly
// clamp path and rational curve numerator / denominator, three stages
// ----------------------------------------------------------------------------
module aceq_poly (
  input  logic               clk,
  input  logic               en,
  input  logic               mode,
  input  logic [31:0]        x,
  output aceq_pkg::aceq_div_t dq
);

  localparam logic [31:0] One   = 32'(1) << aceq_pkg::FracBits;
  localparam logic [31:0] Eight = 32'(8) << aceq_pkg::FracBits;

  // stage 1
  logic [aceq_pkg::XW-1:0] x1_r;
  logic [aceq_pkg::AW-1:0] a1_r, b1_r;
  logic                    byp1_r;
  logic [7:0]              bval1_r;
  // stage 2
  logic [aceq_pkg::PW-1:0] num2_r, den2_r;
  logic                    byp2_r;
  logic [7:0]              bval2_r;
  // stage 3
  aceq_pkg::aceq_div_t     dq_r;

  logic [aceq_pkg::XW-1:0] xs;
  logic [23:0]             clamp_prod;
  logic [7:0]              clamp_v;
  logic                    big, ge_one, num_ge;

  always_comb begin
    xs         = x[aceq_pkg::XW-1:0];
    big        = (x >= Eight);
    ge_one     = (x >= One);
    clamp_prod = 24'(x[15:0]) * 24'd255 + 24'd32768;
    clamp_v    = clamp_prod[23:16];
    num_ge     = (num2_r >= den2_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= xs;
      a1_r    <= aceq_pkg::AW'(xs) * aceq_pkg::AW'(251) + aceq_pkg::AW'(3 * 65536);
      b1_r    <= aceq_pkg::AW'(xs) * aceq_pkg::AW'(243) + aceq_pkg::AW'(59 * 65536);
      byp1_r  <= !mode || big;
      bval1_r <= (mode || ge_one) ? aceq_pkg::ByteMax : clamp_v;

      num2_r  <= aceq_pkg::PW'(x1_r) * aceq_pkg::PW'(a1_r);
      den2_r  <= aceq_pkg::PW'(x1_r) * aceq_pkg::PW'(b1_r)
                 + (aceq_pkg::PW'(14) << (2 * aceq_pkg::FracBits));
      byp2_r  <= byp1_r;
      bval2_r <= bval1_r;

      // ratio at or above one saturates
      dq_r.byp  <= byp2_r || num_ge;
      dq_r.bval <= byp2_r ? bval2_r : aceq_pkg::ByteMax;
      dq_r.n    <= (aceq_pkg::NW'(num2_r) << 9) - aceq_pkg::NW'(num2_r) - aceq_pkg::NW'(num2_r)
                   + aceq_pkg::NW'(den2_r);
      dq_r.d    <= aceq_pkg::DW'(den2_r) << 1;
    end
  end

  assign dq = dq_r;

endmodule

// File: src/aceq_div.sv
// ----------------------------------------------------------------------------
// aceq_div
// eight-stage restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module aceq_div (
  input  logic                clk,
  input  logic                en,
  input  aceq_pkg::aceq_div_t dq,
  output logic [7:0]          q_out
);

  localparam int NB = aceq_pkg::QBits;

  logic [aceq_pkg::NW-1:0] rem_r  [NB];
  logic [aceq_pkg::DW-1:0] d_r    [NB];
  logic [NB-1:0]           q_r    [NB];
  logic                    byp_r  [NB];
  logic [7:0]              bval_r [NB];

  for (genvar k = 0; k < NB; k++) begin : g_step
    logic [aceq_pkg::NW-1:0] rem_src, dsh;
    logic [aceq_pkg::DW-1:0] d_src;
    logic [NB-1:0]           q_src;
    logic                    byp_src, hit;
    logic [7:0]              bval_src;

    if (k == 0) begin : g_first
      assign rem_src  = dq.n;
      assign d_src    = dq.d;
      assign q_src    = '0;
      assign byp_src  = dq.byp;
      assign bval_src = dq.bval;
    end else begin : g_next
      assign rem_src  = rem_r[k-1];
      assign d_src    = d_r[k-1];
      assign q_src    = q_r[k-1];
      assign byp_src  = byp_r[k-1];
      assign bval_src = bval_r[k-1];
    end

    assign dsh = aceq_pkg::NW'(d_src) << (NB - 1 - k);
    assign hit = (rem_src >= dsh);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= hit ? rem_src - dsh : rem_src;
        d_r[k]    <= d_src;
        q_r[k]    <= {q_src[NB-2:0], hit};
        byp_r[k]  <= byp_src;
        bval_r[k] <= bval_src;
      end
    end
  end

  assign q_out = byp_r[NB-1] ? bval_r[NB-1] : q_r[NB-1];

endmodule

// File: src/aces_tonemap_pixel_quantizer.sv
// pipeline: 3 curve stages, then 8 divider stages
// throughput: one pixel per clock; the whole pipe advances unless the output stalls
// the restoring divider takes one quotient bit per stage, so it sets the depth
// reset: synchronous active-low rst_n clears valid bits and tonemap_enable
// ----------------------------------------------------------------------------
// aces_tonemap_pixel_quantizer
// hdr rgb pixel to bgra bytes with optional filmic curve
// ----------------------------------------------------------------------------
`include "aces_tonemap_pixel_quantizer_defines.svh"

module aces_tonemap_pixel_quantizer #(
  parameter int INPUT_WIDTH = aceq_pkg::InputWidthDef
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic                                  cfg_data,    // tonemap_enable
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // red_in, green_in, blue_in, zero pad
  input  logic [((3*INPUT_WIDTH+7)/8)*8-1:0]    in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [31:0]                           out_tdata    // blue, green, red, alpha
);

  localparam int Lat = aceq_pkg::Lat;

  logic           mode_r;
  logic [Lat-1:0] vld_r;
  logic           en;
  logic [31:0]    xin [3];
  logic [7:0]     qv  [3];
  aceq_pkg::aceq_div_t dq [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid) begin
      mode_r <= cfg_data;
    end
  end

  assign en        = !vld_r[Lat-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Lat-2:0], in_tvalid};
    end
  end

  // channel order red, green, blue
  for (genvar c = 0; c < 3; c++) begin : g_chan
    assign xin[c] = 32'(in_tdata[c*INPUT_WIDTH +: INPUT_WIDTH]);

    aceq_poly u_poly (
      .clk  (clk),
      .en   (en),
      .mode (mode_r),
      .x    (xin[c]),
      .dq   (dq[c])
    );

    aceq_div u_div (
      .clk   (clk),
      .en    (en),
      .dq    (dq[c]),
      .q_out (qv[c])
    );
  end

  assign out_tvalid = vld_r[Lat-1];
  assign out_tdata  = {aceq_pkg::ByteMax, qv[0], qv[1], qv[2]};

  `ACEQ_ASSERT_NOW(a_alpha_opaque, out_tvalid, out_tdata[31:24] == aceq_pkg::ByteMax)
  `ACEQ_ASSERT_NOW(a_ready_follows_out, 1'b1, in_tready == (!out_tvalid || out_tready))
  `ACEQ_ASSERT_NEXT(a_stall_holds_pipe, out_tvalid && !out_tready, $stable(vld_r))
  `ACEQ_ASSERT_RST(a_rst_empty, !out_tvalid && !mode_r)

endmodule

// File: sim/tb_aces_tonemap_pixel_quantizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aces_tonemap_pixel_quantizer
// drives hdr pixels through the quantizer in clamp and curve mode and checks
// every bgra byte against an exact integer prediction
// ----------------------------------------------------------------------------

class bgra_scoreboard;
  logic [31:0] pending_bgra[$];
  bit          tonemap_on;
  int          errors;
  int          checked;

  function logic [7:0] channel_byte(logic [23:0] raw);
    logic [63:0] x;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] one;
    one = 64'd1 << 16;
    x = {40'd0, raw};
    if (!tonemap_on) begin
      if (x >= one) return 8'hFF;
      return 8'((255 * x + (one >> 1)) >> 16);
    end
    if (x >= 8 * one) return 8'hFF;
    num = x * (251 * x + 3 * one);
    den = x * (243 * x + 59 * one) + 14 * one * one;
    if (num >= den) return 8'hFF;
    return 8'((510 * num + den) / (2 * den));
  endfunction

  function void note_pixel(logic [71:0] pix);
    logic [31:0] exp_v;
    exp_v = {8'hFF, channel_byte(pix[23:0]), channel_byte(pix[47:24]),
             channel_byte(pix[71:48])};
    pending_bgra = {pending_bgra, exp_v};
  endfunction

  function void check_bgra(logic [31:0] got);
    logic [31:0] exp_v;
    if (pending_bgra.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp_v = pending_bgra.pop_front();
    checked++;
    for (int i = 0; i < 4; i++)
      if (exp_v[8*i +: 8] !== got[8*i +: 8]) begin
        $display("%0t: byte %0d expected %h actual %h", $time, i,
                 exp_v[8*i +: 8], got[8*i +: 8]);
        errors++;
      end
  endfunction
endclass

module tb_aces_tonemap_pixel_quantizer;
  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;    // red, green, blue
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // blue, green, red, alpha

  bgra_scoreboard sb;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_off;
  int  modes_seen;

  aces_tonemap_pixel_quantizer dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_bgra(out_tdata);

  function logic [23:0] rand_channel();
    case ($urandom_range(5))
      0: return 24'($urandom);
      1: return 24'($urandom_range(65536));
      2: return 24'($urandom_range(8 * 65536));
      3: return 24'd65536 + 24'($urandom_range(3)) - 24'd2;
      default: return 24'($urandom_range(3 * 65536));
    endcase
  endfunction

  // valid stays up between back-to-back requests, drain drops it
  task automatic send_pixel(logic [23:0] r, logic [23:0] g, logic [23:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {b, g, r};
    do @(posedge clk); while (!in_tready);
    sb.note_pixel({b, g, r});
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_bgra.size() != 0) @(negedge clk);
    repeat (15) @(negedge clk);
  endtask

  task automatic write_mode(bit en);
    cfg_valid <= 1'b1;
    cfg_data <= en;
    do @(posedge clk); while (!cfg_ready);
    sb.tonemap_on = en;
    modes_seen++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic directed_set();
    send_pixel(24'd0, 24'hFFFFFF, 24'd65536);
    send_pixel(24'd65535, 24'd32768, 24'd128);
    send_pixel(24'(8 * 65536), 24'(8 * 65536 - 1), 24'd1);
    send_pixel(24'h555555, 24'hAAAAAA, 24'd256);
    send_pixel(24'd65537, 24'd193, 24'(3 * 65536));
  endtask

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) send_pixel(rand_channel(), rand_channel(), rand_channel());
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    hold_off = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset mode is clamp
    directed_set();
    drain();
    write_mode(1'b1);
    directed_set();
    drain();

    send_idle_pct = 37;
    recv_idle_pct = 74;
    random_run(120);
    drain();
    write_mode(1'b0);
    random_run(110);
    drain();

    send_idle_pct = 74;
    recv_idle_pct = 37;
    random_run(110);
    drain();
    write_mode(1'b1);
    random_run(110);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 60;
    random_run(120);
    drain();
    write_mode(1'b0);
    random_run(120);
    drain();

    $display("tb: %0d pixels checked over %0d mode writes, clamp and curve", sb.checked,
             modes_seen);
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
